@@ design/fpa_pkg.sv @@
package fpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
  localparam int WIDE_BITS = 2 * WORD_BITS + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WIDE_BITS-1:0] wide_t;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MAX      = 4'd10,
    OP_MIN      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } opc_e;

  typedef struct packed {
    logic [3:0] opcode;
    word_t      operand_a;
    word_t      operand_b;
  } req_t;

  typedef struct packed {
    word_t result_value;
    logic  compare_true;
    logic  overflow;
    logic  divide_by_zero;
  } rsp_t;

  typedef struct packed {
    opc_e  op;
    word_t res;
    logic  cmp;
    logic  ovf;
    logic  dbz;
    logic  neg;
  } side_t;

  typedef struct packed {
    logic [DIV_BITS-1:0]  num;
    logic [WORD_BITS-1:0] den;
    logic [WORD_BITS-1:0] rem;
    side_t                side;
  } div_t;

  typedef struct packed {
    word_t v;
    logic  o;
  } fin_t;

  function automatic word_t bound_f(logic neg);
    word_t r;
    r = '0;
    r[WORD_BITS-1] = 1'b1;
    if (!neg) begin
      r = ~r;
    end
    return r;
  endfunction

  function automatic fin_t finish_f(wide_t q, logic neg);
    wide_t lim;
    fin_t  f;
    lim = '0;
    lim[WORD_BITS-1] = 1'b1;
    if (!neg) begin
      lim = lim - 1'b1;
    end
    f.o = q > lim;
    if (f.o) begin
      f.v = bound_f(neg);
    end else if (neg) begin
      f.v = word_t'(-q[WORD_BITS-1:0]);
    end else begin
      f.v = word_t'(q[WORD_BITS-1:0]);
    end
    return f;
  endfunction

  function automatic div_t div_step(div_t x);
    logic [WORD_BITS:0] sh;
    logic               ge;
    div_t               y;
    y  = x;
    sh = {x.rem, x.num[DIV_BITS-1]};
    ge = sh >= {1'b0, x.den};
    if (ge) begin
      sh = sh - {1'b0, x.den};
    end
    y.rem = sh[WORD_BITS-1:0];
    y.num = {x.num[DIV_BITS-2:0], ge};
    return y;
  endfunction

endpackage

@@ design/fixed_point_alu.sv @@
// Signed fixed-point ALU, Q24.8 on 32-bit raw words. One request per cycle is
// accepted while the output is not stalled; every request, whatever its opcode,
// leaves in order through the divider: one quotient bit per stage over 40
// stages, behind three stages of operand capture, simple ops, multiply and
// product rounding, and followed by the output register. A stall at the
// output holds the whole pipeline.
module fixed_point_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  fpa_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output fpa_pkg::rsp_t rsp_o
);

  localparam int W = fpa_pkg::WORD_BITS;
  localparam int F = fpa_pkg::FRAC_BITS;
  localparam int D = fpa_pkg::DIV_BITS;

  logic en;
  logic s1_valid_q, s2_valid_q, s3_valid_q, rsp_valid_q;
  fpa_pkg::req_t  s1_q;
  fpa_pkg::div_t  s2_d, s2_q, s3_d, s3_q;
  logic [2*W-1:0] prod_d, prod_q;
  logic           dv_valid;
  fpa_pkg::div_t  dv;
  fpa_pkg::rsp_t  rsp_d, rsp_q;

  assign en          = !(rsp_valid_q && rsp_stall_i);
  assign req_stall_o = !en;

  logic [W:0]     sum, dif, inc, dec;
  fpa_pkg::word_t a, b, fi;
  logic [W-1:0]   ma, mb;
  fpa_pkg::opc_e  op;

  always_comb begin
    a   = s1_q.operand_a;
    b   = s1_q.operand_b;
    op  = fpa_pkg::opc_e'(s1_q.opcode);
    sum = {a[W-1], a} + {b[W-1], b};
    dif = {a[W-1], a} - {b[W-1], b};
    inc = {a[W-1], a} + 1'b1;
    dec = {a[W-1], a} - 1'b1;
    fi  = a <<< F;
    ma  = a[W-1] ? (~a + 1'b1) : a;
    mb  = b[W-1] ? (~b + 1'b1) : b;
    prod_d = ma * mb;
    s2_d.num = {ma, {F{1'b0}}};
    s2_d.den = mb;
    s2_d.rem = '0;
    s2_d.side.op  = op;
    s2_d.side.res = '0;
    s2_d.side.cmp = 1'b0;
    s2_d.side.ovf = 1'b0;
    s2_d.side.dbz = 1'b0;
    s2_d.side.neg = a[W-1] ^ b[W-1];
    case (op)
      fpa_pkg::OP_ADD: begin
        s2_d.side.ovf = sum[W] != sum[W-1];
        s2_d.side.res = s2_d.side.ovf ? fpa_pkg::bound_f(a[W-1]) : sum[W-1:0];
      end
      fpa_pkg::OP_SUB: begin
        s2_d.side.ovf = dif[W] != dif[W-1];
        s2_d.side.res = s2_d.side.ovf ? fpa_pkg::bound_f(a[W-1]) : dif[W-1:0];
      end
      fpa_pkg::OP_INC: begin
        s2_d.side.ovf = inc[W] != inc[W-1];
        s2_d.side.res = s2_d.side.ovf ? fpa_pkg::bound_f(a[W-1]) : inc[W-1:0];
      end
      fpa_pkg::OP_DEC: begin
        s2_d.side.ovf = dec[W] != dec[W-1];
        s2_d.side.res = s2_d.side.ovf ? fpa_pkg::bound_f(a[W-1]) : dec[W-1:0];
      end
      fpa_pkg::OP_DIV:  s2_d.side.dbz = b == '0;
      fpa_pkg::OP_GT:   s2_d.side.cmp = a > b;
      fpa_pkg::OP_LT:   s2_d.side.cmp = a < b;
      fpa_pkg::OP_GE:   s2_d.side.cmp = a >= b;
      fpa_pkg::OP_LE:   s2_d.side.cmp = a <= b;
      fpa_pkg::OP_EQ:   s2_d.side.cmp = a == b;
      fpa_pkg::OP_NE:   s2_d.side.cmp = a != b;
      fpa_pkg::OP_MAX:  s2_d.side.res = (b < a) ? a : b;
      fpa_pkg::OP_MIN:  s2_d.side.res = (a < b) ? a : b;
      fpa_pkg::OP_TO_INT: s2_d.side.res = a >>> F;
      fpa_pkg::OP_FROM_INT: begin
        s2_d.side.ovf = (fi >>> F) != a;
        s2_d.side.res = s2_d.side.ovf ? fpa_pkg::bound_f(a[W-1]) : fi;
      end
      default: s2_d.side.res = '0;
    endcase
  end

  fpa_pkg::wide_t mq;
  fpa_pkg::fin_t  mf;

  always_comb begin
    mq   = ({1'b0, prod_q} + (fpa_pkg::wide_t'(1) << (F - 1))) >> F;
    mf   = fpa_pkg::finish_f(mq, s2_q.side.neg);
    s3_d = s2_q;
    if (s2_q.side.op == fpa_pkg::OP_MUL) begin
      s3_d.side.res = mf.v;
      s3_d.side.ovf = mf.o;
    end
  end

  fpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .data_i  (s3_q),
    .valid_o (dv_valid),
    .data_o  (dv)
  );

  logic           rnd;
  logic [D:0]     dq;
  fpa_pkg::fin_t  df;

  always_comb begin
    rnd = {dv.rem, 1'b0} >= {1'b0, dv.den};
    dq  = {1'b0, dv.num} + {{D{1'b0}}, rnd};
    df  = fpa_pkg::finish_f(fpa_pkg::wide_t'(dq), dv.side.neg);
    rsp_d.result_value   = dv.side.res;
    rsp_d.compare_true   = dv.side.cmp;
    rsp_d.overflow       = dv.side.ovf;
    rsp_d.divide_by_zero = dv.side.dbz;
    if (dv.side.op == fpa_pkg::OP_DIV && !dv.side.dbz) begin
      rsp_d.result_value = df.v;
      rsp_d.overflow     = df.o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= req_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      rsp_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= req_i;
      s2_q   <= s2_d;
      prod_q <= prod_d;
      s3_q   <= s3_d;
      rsp_q  <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ design/fpa_div.sv @@
module fpa_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fpa_pkg::div_t    data_i,
  output logic             valid_o,
  output fpa_pkg::div_t    data_o
);

  localparam int N = fpa_pkg::DIV_BITS;

  fpa_pkg::div_t stage_q [N];
  logic [N-1:0]  valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= fpa_pkg::div_step(data_i);
      for (int k = 1; k < N; k++) begin
        stage_q[k] <= fpa_pkg::div_step(stage_q[k-1]);
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign data_o  = stage_q[N-1];

endmodule
